/* rtl/assert_macros.svh */
// Assertion macros used by the RTL scan module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CHK_IMPL(LBL, ANTE, CONS) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define CHK_NEXT(LBL, ANTE, CONS) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |=> (CONS)) \
    else $error("next-cycle check failed");

`endif

/* rtl/pdins_pkg.sv */
// Package for the pickup/delivery insertion scan: widths, constants, types.
`timescale 1ns / 1ps

package pdins_pkg;

  localparam int COST_W     = 24;  // 16.8 unsigned arc cost
  localparam int LOAD_W     = 16;
  localparam int DEM_W      = 15;
  localparam int CH_W       = 27;  // signed cost change, three arcs minus one
  localparam int SUM_W      = 28;  // sum of two change minima
  localparam int BEST_W     = 31;
  localparam int POS_W      = 8;   // emitted position width
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int ROUTE_MAX_DEF = 256;

  localparam logic signed [BEST_W-1:0] NO_INSERT_COST = BEST_W'(999999999);
  localparam logic [DEM_W-1:0] CAPACITY_RST = {DEM_W{1'b1}};

  typedef enum logic [1:0] {
    REG_PICKUP_DEMAND    = 2'd0,
    REG_VEHICLE_CAPACITY = 2'd1,
    REG_PD_COST          = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COST_W-1:0]        old_arc;
    logic [COST_W-1:0]        p_in;
    logic [COST_W-1:0]        p_out;
    logic [COST_W-1:0]        d_in;
    logic [COST_W-1:0]        d_out;
    logic signed [LOAD_W-1:0] load;
    logic                     last;
  } item_t;

endpackage

/* rtl/pickup_delivery_insertion_scan.sv */
// Pickup/delivery insertion scan: top level with input stage, scan state and result register.
//
// Takes one route position per item, one item every clock cycle, and returns one result
// on the item marked last_position. An accepted item sits in the input register, where
// a single combinational pass forms the pickup, delivery and together cost changes,
// updates the segment minima and closes the segment; the result register then presents
// the outcome, so out_valid rises once the last item has passed from the input register
// into the result register. That single pass sets the rate of one item per cycle; a
// stalled result holds an item marked last and those behind it; other items keep flowing.
// Configuration sits at byte addresses 0, 4 and 8 and must be written while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pickup_delivery_insertion_scan
  import pdins_pkg::*;
#(
  parameter int ROUTE_MAX = ROUTE_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // position items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COST_W-1:0]        in_cost_prev_to_next,
  input  logic [COST_W-1:0]        in_cost_prev_to_pickup,
  input  logic [COST_W-1:0]        in_cost_pickup_to_next,
  input  logic [COST_W-1:0]        in_cost_prev_to_delivery,
  input  logic [COST_W-1:0]        in_cost_delivery_to_next,
  input  logic signed [LOAD_W-1:0] in_load_at_position,
  input  logic                     in_last_position,
  // results
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         out_pickup_position,
  output logic [POS_W-1:0]         out_delivery_position,
  output logic signed [BEST_W-1:0] out_best_cost
);

  localparam int CNT_W = $clog2(ROUTE_MAX);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ROUTE_MAX - 1);
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);

  // configuration registers
  logic [DEM_W-1:0]  demand_r;
  logic [DEM_W-1:0]  capacity_r;
  logic [COST_W-1:0] pd_cost_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      demand_r   <= '0;
      capacity_r <= CAPACITY_RST;
      pd_cost_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PICKUP_DEMAND:    demand_r   <= pwdata[DEM_W-1:0];
        REG_VEHICLE_CAPACITY: capacity_r <= pwdata[DEM_W-1:0];
        REG_PD_COST:          pd_cost_r  <= pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PICKUP_DEMAND:    prdata = DATA_W'(demand_r);
      REG_VEHICLE_CAPACITY: prdata = DATA_W'(capacity_r);
      REG_PD_COST:          prdata = DATA_W'(pd_cost_r);
      default:              prdata = '0;
    endcase
  end

  // input stage
  item_t stage_r;
  logic  stage_valid_r, stage_valid_nxt;
  logic  advance, in_acc;
  logic  out_valid_r, out_valid_nxt;

  // an item with no result never waits on the output side
  assign advance  = stage_valid_r && (!stage_r.last || !out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_acc)       stage_valid_nxt = 1'b1;
    else if (advance) stage_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) stage_valid_r <= 1'b0;
    else        stage_valid_r <= stage_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r.old_arc <= in_cost_prev_to_next;
      stage_r.p_in    <= in_cost_prev_to_pickup;
      stage_r.p_out   <= in_cost_pickup_to_next;
      stage_r.d_in    <= in_cost_prev_to_delivery;
      stage_r.d_out   <= in_cost_delivery_to_next;
      stage_r.load    <= in_load_at_position;
      stage_r.last    <= in_last_position;
    end
  end

  // scan state
  logic [CNT_W-1:0]         pos_cnt_r, pos_cnt_nxt;
  logic                     seg_open_r, seg_open_nxt;
  logic signed [CH_W-1:0]   minp_r, minp_nxt, mind_r, mind_nxt, mint_r, mint_nxt;
  logic [POS_W-1:0]         posp_r, posp_nxt, posd_r, posd_nxt, post_r, post_nxt;
  logic signed [BEST_W-1:0] best_so_far_r, best_so_far_nxt;
  logic [POS_W-1:0]         bestp_r, bestp_nxt, bestd_r, bestd_nxt;

  logic signed [CH_W-1:0]   pc, dc, tc;
  logic [POS_W+CNT_W-1:0]   pos_ext;
  logic [POS_W-1:0]         pos8;
  logic signed [DEM_W+1:0]  load_sum, cap_ext;
  logic                     close_seg;
  logic signed [SUM_W-1:0]  pair_sum;
  logic signed [SUM_W-1:0]  mint_ext28;
  logic signed [BEST_W-1:0] mint_ext, sum_ext;
  logic signed [BEST_W-1:0] res_best;
  logic [POS_W-1:0]         res_p, res_d;

  assign pos_ext = {{POS_W{1'b0}}, pos_cnt_r};
  assign pos8    = pos_ext[POS_W-1:0];

  assign pc = $signed(CH_W'(stage_r.p_in) + CH_W'(stage_r.p_out) - CH_W'(stage_r.old_arc));
  assign dc = $signed(CH_W'(stage_r.d_in) + CH_W'(stage_r.d_out) - CH_W'(stage_r.old_arc));
  assign tc = $signed(CH_W'(stage_r.p_in) + CH_W'(pd_cost_r) + CH_W'(stage_r.d_out)
                      - CH_W'(stage_r.old_arc));

  assign load_sum  = $signed({stage_r.load[LOAD_W-1], stage_r.load})
                   + $signed({2'b00, demand_r});
  assign cap_ext   = $signed({2'b00, capacity_r});
  assign close_seg = (load_sum > cap_ext) || stage_r.last;

  always_comb begin
    minp_nxt = minp_r;
    mind_nxt = mind_r;
    mint_nxt = mint_r;
    posp_nxt = posp_r;
    posd_nxt = posd_r;
    post_nxt = post_r;
    res_best = best_so_far_r;
    res_p    = bestp_r;
    res_d    = bestd_r;

    if (!seg_open_r) begin
      minp_nxt = pc;
      mind_nxt = dc;
      mint_nxt = tc;
      posp_nxt = pos8;
      posd_nxt = pos8;
      post_nxt = pos8;
    end else begin
      // both below their minima: neither moves
      if (pc >= minp_r || dc >= mind_r) begin
        if (pc < minp_r) begin
          minp_nxt = pc;
          posp_nxt = pos8;
          mind_nxt = dc;
          posd_nxt = pos8;
        end else if (dc < mind_r) begin
          mind_nxt = dc;
          posd_nxt = pos8;
        end
      end
      if (tc < mint_r) begin
        mint_nxt = tc;
        post_nxt = pos8;
      end
    end

    // segment minima including this item
    pair_sum   = $signed({minp_nxt[CH_W-1], minp_nxt})
               + $signed({mind_nxt[CH_W-1], mind_nxt});
    mint_ext28 = $signed({mint_nxt[CH_W-1], mint_nxt});
    mint_ext   = $signed({{(BEST_W-CH_W){mint_nxt[CH_W-1]}}, mint_nxt});
    sum_ext    = $signed({{(BEST_W-SUM_W){pair_sum[SUM_W-1]}}, pair_sum});

    if (close_seg) begin
      if (minp_nxt == mind_nxt || pair_sum > mint_ext28) begin
        if (best_so_far_r >= mint_ext) begin
          res_best = mint_ext;
          res_p    = post_nxt;
          res_d    = post_nxt;
        end
      end else if (best_so_far_r >= sum_ext) begin
        res_best = sum_ext;
        res_p    = posp_nxt;
        res_d    = posd_nxt;
      end
    end

    seg_open_nxt    = !close_seg;
    pos_cnt_nxt     = (pos_cnt_r == CNT_LAST) ? '0 : pos_cnt_r + CNT_W'(1);
    best_so_far_nxt = res_best;
    bestp_nxt       = res_p;
    bestd_nxt       = res_d;

    // end of route: scan state back to its reset values
    if (stage_r.last) begin
      pos_cnt_nxt     = CNT_FIRST;
      seg_open_nxt    = 1'b0;
      minp_nxt        = '0;
      mind_nxt        = '0;
      mint_nxt        = '0;
      posp_nxt        = '0;
      posd_nxt        = '0;
      post_nxt        = '0;
      best_so_far_nxt = NO_INSERT_COST;
      bestp_nxt       = '0;
      bestd_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r     <= CNT_FIRST;
      seg_open_r    <= 1'b0;
      minp_r        <= '0;
      mind_r        <= '0;
      mint_r        <= '0;
      posp_r        <= '0;
      posd_r        <= '0;
      post_r        <= '0;
      best_so_far_r <= NO_INSERT_COST;
      bestp_r       <= '0;
      bestd_r       <= '0;
    end else if (advance) begin
      pos_cnt_r     <= pos_cnt_nxt;
      seg_open_r    <= seg_open_nxt;
      minp_r        <= minp_nxt;
      mind_r        <= mind_nxt;
      mint_r        <= mint_nxt;
      posp_r        <= posp_nxt;
      posd_r        <= posd_nxt;
      post_r        <= post_nxt;
      best_so_far_r <= best_so_far_nxt;
      bestp_r       <= bestp_nxt;
      bestd_r       <= bestd_nxt;
    end
  end

  // result register
  logic [POS_W-1:0]         out_p_r, out_d_r;
  logic signed [BEST_W-1:0] out_best_r;
  logic                     load_out;

  assign load_out = advance && stage_r.last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_p_r    <= res_p;
      out_d_r    <= res_d;
      out_best_r <= res_best;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pickup_position   = out_p_r;
  assign out_delivery_position = out_d_r;
  assign out_best_cost         = out_best_r;

  // a result never overwrites one that is still waiting
  `CHK_IMPL(a_no_result_overwrite, load_out, !out_valid_r || out_ready)
  // the scan restarts cleanly after the route's last position
  `CHK_NEXT(a_clear_after_last, load_out,
            !seg_open_r && best_so_far_r == NO_INSERT_COST && pos_cnt_r == CNT_FIRST)
  // within a route the best cost only improves
  `CHK_NEXT(a_best_monotone, advance && !stage_r.last, best_so_far_r <= $past(best_so_far_r))

endmodule
